@@ hdl/tle_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the terminal line editor: key codes,
// escape decoder phases, result event codes and the sequencer states.
// ---------------------------------------------------------------------------
package tle_pkg;

    // Default line capacity; the line holds at most LINE_CAPACITY-1 characters.
    localparam int LINE_CAPACITY = 64;

    // Received key codes
    localparam logic [7:0] KEY_BS       = 8'h08;
    localparam logic [7:0] KEY_LF       = 8'h0A;
    localparam logic [7:0] KEY_CR       = 8'h0D;
    localparam logic [7:0] KEY_ESC      = 8'h1B;
    localparam logic [7:0] KEY_DEL      = 8'h7F;
    localparam logic [7:0] KEY_LBRACKET = 8'h5B;
    localparam logic [7:0] KEY_O        = 8'h4F;
    localparam logic [7:0] KEY_TILDE    = 8'h7E;
    localparam logic [7:0] KEY_C        = 8'h43;
    localparam logic [7:0] KEY_D        = 8'h44;
    localparam logic [7:0] KEY_H        = 8'h48;
    localparam logic [7:0] KEY_F        = 8'h46;
    localparam logic [7:0] KEY_0        = 8'h30;
    localparam logic [7:0] KEY_9        = 8'h39;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_HI     = 8'h7E;

    // Digits of the ESC [ n ~ form
    localparam logic [3:0] DIGIT_HOME   = 4'd1;
    localparam logic [3:0] DIGIT_DELETE = 4'd3;
    localparam logic [3:0] DIGIT_END    = 4'd4;

    // Escape decoder phases
    localparam logic [2:0] PH_TEXT  = 3'd0;
    localparam logic [2:0] PH_ESC   = 3'd1;
    localparam logic [2:0] PH_CSI   = 3'd2;
    localparam logic [2:0] PH_DIGIT = 3'd3;
    localparam logic [2:0] PH_SS3   = 3'd4;

    // Result event codes
    localparam logic [2:0] EV_NONE         = 3'd0;
    localparam logic [2:0] EV_INSERTED     = 3'd1;
    localparam logic [2:0] EV_ERASE_BEFORE = 3'd2;
    localparam logic [2:0] EV_ERASE_AT     = 3'd3;
    localparam logic [2:0] EV_MOVED        = 3'd4;
    localparam logic [2:0] EV_LINE_CHAR    = 3'd5;
    localparam logic [2:0] EV_EMPTY_LINE   = 3'd6;

    // Work selected by the decoder for one received byte
    typedef enum logic [2:0] {
        OP_POST,
        OP_INSERT,
        OP_ERASE_AT,
        OP_ERASE_BEFORE,
        OP_EMIT
    } op_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SHIFT = 4'b0010,
        ST_POST  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage
`default_nettype wire

@@ hdl/tle_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hdl/terminal_line_editor.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// terminal_line_editor
// Editable terminal line with cursor, escape key decoding and line submit.
// ---------------------------------------------------------------------------
// Takes received terminal bytes one beat at a time and keeps a line of text
// with a cursor in a RAM with one write port and one registered read port.
// Cursor keys (ESC[C/D/H/F, ESC[1~/4~, ESC O H/F) and the no-op bytes
// give one result beat through the POST state and the output register. Insert,
// backspace/DEL and ESC[3~ shift the tail of the line through the RAM one
// byte per cycle and then post one result beat. CR or LF on a non-empty
// line streams the line out as one event-5 beat per character, one per
// cycle while m_ready is high, the final beat flagged with m_last; an empty
// line gives one event-6 beat.
// A new input beat is taken as soon as the sequencer is back in idle, even
// while the last result beat still waits in the output register.
// ---------------------------------------------------------------------------
module terminal_line_editor #(
    parameter int LINE_CAPACITY = tle_pkg::LINE_CAPACITY
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input byte channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_byte,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_res,
    output logic [7:0]      m_line_char,
    output logic [5:0]      m_cursor_pos,
    output logic [5:0]      m_line_length,
    output logic            m_last
);

    localparam int         AW      = $clog2(LINE_CAPACITY);
    localparam logic [5:0] MAX_LEN = 6'(LINE_CAPACITY - 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tle_pkg::state_t state_reg, state_next;

    logic [2:0] phase_reg,  phase_next;
    logic [3:0] digit_reg,  digit_next;
    logic [5:0] cursor_reg, cursor_next;
    logic [5:0] length_reg, length_next;

    // shift / emit sequencer
    logic [5:0] ptr_reg,      ptr_next;      // next RAM read index
    logic [5:0] cnt_reg,      cnt_next;      // reads left (shift) or last index (emit)
    logic       up_reg,       up_next;       // 1: ascending reads (erase)
    logic       ins_reg,      ins_next;      // final write of the new char
    logic       pend_reg,     pend_next;     // read data due to be written back
    logic [5:0] wr_addr_reg,  wr_addr_next;
    logic [5:0] ins_addr_reg, ins_addr_next;
    logic [7:0] ins_char_reg, ins_char_next;
    logic [2:0] evt_reg,      evt_next;

    // output register
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_event_reg;
    logic [7:0] m_char_reg;
    logic [5:0] m_cursor_reg;
    logic [5:0] m_length_reg;
    logic       m_last_reg;

    logic       out_load;
    logic [2:0] out_event;
    logic [7:0] out_char;
    logic       out_last;
    logic       out_free;

    // RAM port
    logic          ram_we;
    logic [5:0]    ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [5:0]    ram_raddr;
    logic [7:0]    ram_rdata;

    // ------------------------------------------------------------------
    // Byte decoder: what one received byte does to the line
    // ------------------------------------------------------------------
    logic           dec_eol;
    logic           dec_digit_key;
    logic           dec_print;
    logic [2:0]     dec_phase;
    logic [3:0]     dec_digit;
    logic [5:0]     dec_cursor;
    logic [5:0]     dec_length;
    logic [2:0]     dec_event;
    tle_pkg::op_t   dec_op;

    assign dec_eol       = (s_rx_byte == tle_pkg::KEY_CR) || (s_rx_byte == tle_pkg::KEY_LF);
    assign dec_digit_key = (s_rx_byte >= tle_pkg::KEY_0) && (s_rx_byte <= tle_pkg::KEY_9);
    assign dec_print     = (s_rx_byte >= tle_pkg::PRINT_LO) && (s_rx_byte <= tle_pkg::PRINT_HI);

    always_comb begin
        dec_phase  = phase_reg;
        dec_digit  = digit_reg;
        dec_cursor = cursor_reg;
        dec_length = length_reg;
        dec_event  = tle_pkg::EV_NONE;
        dec_op     = tle_pkg::OP_POST;

        if (dec_eol) begin
            // line end is honored in any escape phase and leaves it alone
            dec_cursor = '0;
            if (length_reg == '0) begin
                dec_event = tle_pkg::EV_EMPTY_LINE;
            end else begin
                dec_length = '0;
                dec_op     = tle_pkg::OP_EMIT;
            end
        end else if (s_rx_byte == tle_pkg::KEY_ESC) begin
            dec_phase = tle_pkg::PH_ESC;
            dec_digit = '0;
        end else if (phase_reg == tle_pkg::PH_ESC && s_rx_byte == tle_pkg::KEY_LBRACKET) begin
            dec_phase = tle_pkg::PH_CSI;
        end else if (phase_reg == tle_pkg::PH_ESC && s_rx_byte == tle_pkg::KEY_O) begin
            dec_phase = tle_pkg::PH_SS3;
        end else if (phase_reg == tle_pkg::PH_CSI) begin
            if (dec_digit_key) begin
                dec_digit = s_rx_byte[3:0];
                dec_phase = tle_pkg::PH_DIGIT;
            end else begin
                dec_phase = tle_pkg::PH_TEXT;
                if (s_rx_byte == tle_pkg::KEY_C) begin
                    if (cursor_reg < length_reg) begin
                        dec_cursor = cursor_reg + 6'd1;
                        dec_event  = tle_pkg::EV_MOVED;
                    end
                end else if (s_rx_byte == tle_pkg::KEY_D) begin
                    if (cursor_reg != '0) begin
                        dec_cursor = cursor_reg - 6'd1;
                        dec_event  = tle_pkg::EV_MOVED;
                    end
                end else if (s_rx_byte == tle_pkg::KEY_H) begin
                    if (cursor_reg != '0) begin
                        dec_cursor = '0;
                        dec_event  = tle_pkg::EV_MOVED;
                    end
                end else if (s_rx_byte == tle_pkg::KEY_F) begin
                    if (cursor_reg < length_reg) begin
                        dec_cursor = length_reg;
                        dec_event  = tle_pkg::EV_MOVED;
                    end
                end
            end
        end else if (phase_reg == tle_pkg::PH_DIGIT && s_rx_byte == tle_pkg::KEY_TILDE) begin
            dec_phase = tle_pkg::PH_TEXT;
            dec_digit = '0;
            if (digit_reg == tle_pkg::DIGIT_DELETE) begin
                if (cursor_reg < length_reg) begin
                    dec_length = length_reg - 6'd1;
                    dec_event  = tle_pkg::EV_ERASE_AT;
                    dec_op     = tle_pkg::OP_ERASE_AT;
                end
            end else if (digit_reg == tle_pkg::DIGIT_HOME) begin
                if (cursor_reg != '0) begin
                    dec_cursor = '0;
                    dec_event  = tle_pkg::EV_MOVED;
                end
            end else if (digit_reg == tle_pkg::DIGIT_END) begin
                if (cursor_reg < length_reg) begin
                    dec_cursor = length_reg;
                    dec_event  = tle_pkg::EV_MOVED;
                end
            end
        end else if (phase_reg == tle_pkg::PH_SS3) begin
            dec_phase = tle_pkg::PH_TEXT;
            if (s_rx_byte == tle_pkg::KEY_H) begin
                if (cursor_reg != '0) begin
                    dec_cursor = '0;
                    dec_event  = tle_pkg::EV_MOVED;
                end
            end else if (s_rx_byte == tle_pkg::KEY_F) begin
                if (cursor_reg < length_reg) begin
                    dec_cursor = length_reg;
                    dec_event  = tle_pkg::EV_MOVED;
                end
            end
        end else begin
            // plain text, including a second digit and bytes after a lone ESC
            dec_phase = tle_pkg::PH_TEXT;
            dec_digit = '0;
            if (s_rx_byte == tle_pkg::KEY_BS || s_rx_byte == tle_pkg::KEY_DEL) begin
                if (cursor_reg != '0 && length_reg != '0) begin
                    dec_cursor = cursor_reg - 6'd1;
                    dec_length = length_reg - 6'd1;
                    dec_event  = tle_pkg::EV_ERASE_BEFORE;
                    dec_op     = tle_pkg::OP_ERASE_BEFORE;
                end
            end else if (dec_print) begin
                if (length_reg < MAX_LEN) begin
                    dec_cursor = cursor_reg + 6'd1;
                    dec_length = length_reg + 6'd1;
                    dec_event  = tle_pkg::EV_INSERTED;
                    dec_op     = tle_pkg::OP_INSERT;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == tle_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        cursor_next   = cursor_reg;
        length_next   = length_reg;
        ptr_next      = ptr_reg;
        cnt_next      = cnt_reg;
        up_next       = up_reg;
        ins_next      = ins_reg;
        pend_next     = pend_reg;
        wr_addr_next  = wr_addr_reg;
        ins_addr_next = ins_addr_reg;
        ins_char_next = ins_char_reg;
        evt_next      = evt_reg;

        ram_we    = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = ptr_reg;

        out_load  = 1'b0;
        out_event = evt_reg;
        out_char  = '0;
        out_last  = 1'b1;

        unique case (state_reg)
            tle_pkg::ST_IDLE: begin
                ram_raddr = '0;
                if (s_valid) begin
                    phase_next    = dec_phase;
                    digit_next    = dec_digit;
                    cursor_next   = dec_cursor;
                    length_next   = dec_length;
                    evt_next      = dec_event;
                    pend_next     = 1'b0;
                    ins_next      = 1'b0;
                    ins_addr_next = cursor_reg;
                    ins_char_next = s_rx_byte;
                    case (dec_op)
                        tle_pkg::OP_INSERT: begin
                            // move tail right, from the end down to the cursor
                            ptr_next   = length_reg - 6'd1;
                            cnt_next   = length_reg - cursor_reg;
                            up_next    = 1'b0;
                            ins_next   = 1'b1;
                            state_next = tle_pkg::ST_SHIFT;
                        end
                        tle_pkg::OP_ERASE_AT: begin
                            ptr_next   = cursor_reg + 6'd1;
                            cnt_next   = length_reg - cursor_reg - 6'd1;
                            up_next    = 1'b1;
                            state_next = tle_pkg::ST_SHIFT;
                        end
                        tle_pkg::OP_ERASE_BEFORE: begin
                            ptr_next   = cursor_reg;
                            cnt_next   = length_reg - cursor_reg;
                            up_next    = 1'b1;
                            state_next = tle_pkg::ST_SHIFT;
                        end
                        tle_pkg::OP_EMIT: begin
                            // fetch the first character now
                            ram_re     = 1'b1;
                            ptr_next   = '0;
                            cnt_next   = length_reg - 6'd1;
                            state_next = tle_pkg::ST_EMIT;
                        end
                        default: begin
                            state_next = tle_pkg::ST_POST;
                        end
                    endcase
                end
            end

            tle_pkg::ST_SHIFT: begin
                // read one byte ahead, write the previous one back a slot over
                if (cnt_reg != '0) begin
                    ram_re       = 1'b1;
                    cnt_next     = cnt_reg - 6'd1;
                    pend_next    = 1'b1;
                    wr_addr_next = up_reg ? ptr_reg - 6'd1 : ptr_reg + 6'd1;
                    ptr_next     = up_reg ? ptr_reg + 6'd1 : ptr_reg - 6'd1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    ram_we = 1'b1;
                end else if (cnt_reg == '0) begin
                    // tail is moved: drop the new char into the gap
                    if (ins_reg) begin
                        ram_we    = 1'b1;
                        ram_waddr = ins_addr_reg;
                        ram_wdata = ins_char_reg;
                    end
                    state_next = tle_pkg::ST_POST;
                end
            end

            tle_pkg::ST_POST: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = tle_pkg::ST_IDLE;
                end
            end

            tle_pkg::ST_EMIT: begin
                ram_raddr = ptr_reg + 6'd1;
                out_event = tle_pkg::EV_LINE_CHAR;
                out_char  = ram_rdata;
                out_last  = (ptr_reg == cnt_reg);
                // hold the read data until the output register takes it
                if (out_free) begin
                    out_load = 1'b1;
                    if (ptr_reg == cnt_reg) begin
                        state_next = tle_pkg::ST_IDLE;
                    end else begin
                        ram_re   = 1'b1;
                        ptr_next = ptr_reg + 6'd1;
                    end
                end
            end

            default: begin
                state_next = tle_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tle_pkg::ST_IDLE;
            phase_reg   <= tle_pkg::PH_TEXT;
            digit_reg   <= '0;
            cursor_reg  <= '0;
            length_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            digit_reg   <= digit_next;
            cursor_reg  <= cursor_next;
            length_reg  <= length_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        ptr_reg      <= ptr_next;
        cnt_reg      <= cnt_next;
        up_reg       <= up_next;
        ins_reg      <= ins_next;
        wr_addr_reg  <= wr_addr_next;
        ins_addr_reg <= ins_addr_next;
        ins_char_reg <= ins_char_next;
        evt_reg      <= evt_next;
        if (out_load) begin
            m_event_reg  <= out_event;
            m_char_reg   <= out_char;
            m_cursor_reg <= cursor_reg;
            m_length_reg <= length_reg;
            m_last_reg   <= out_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_event_res   = m_event_reg;
    assign m_line_char   = m_char_reg;
    assign m_cursor_pos  = m_cursor_reg;
    assign m_line_length = m_length_reg;
    assign m_last        = m_last_reg;

    // ------------------------------------------------------------------
    // Line store
    // ------------------------------------------------------------------
    tle_ram #(
        .WIDTH  (8),
        .DEPTH  (LINE_CAPACITY),
        .ADDR_W (AW)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr[AW-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr[AW-1:0]),
        .rd_data (ram_rdata)
    );

`ifndef SYNTHESIS
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= length_reg)
        else $error("cursor beyond end of line");

    a_length_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        length_reg <= MAX_LEN)
        else $error("line length over capacity");

    a_shift_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tle_pkg::ST_SHIFT) && pend_reg && (cnt_reg != '0)
        |-> wr_addr_reg != ptr_reg)
        else $error("write-back collides with read in shift");

    a_emit_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tle_pkg::ST_EMIT) |-> (cursor_reg == '0) && (length_reg == '0))
        else $error("line not cleared while streaming");

    a_non_last_is_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_last_reg |-> m_event_reg == tle_pkg::EV_LINE_CHAR)
        else $error("non-final beat that is not a line character");
`endif

endmodule
`default_nettype wire
